// ===== rtl/tte_pkg.sv =====
// ----------------------------------------------------------------------------
// Timeout table engine package
// Shared constants for the timeout table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tte_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int ID_W      = 16;
    localparam int DL_W      = 32;
    localparam int ENTRY_W   = ID_W + DL_W;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_SET     = 3'd1;
    localparam logic [2:0] CMD_DELETE  = 3'd2;
    localparam logic [2:0] CMD_CHECK   = 3'd3;
    localparam logic [2:0] CMD_GET     = 3'd4;
    localparam logic [2:0] CMD_NEAREST = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RANGE    = 3'd1;
    localparam logic [2:0] ST_BAD_ID   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_ELAPSED  = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;
    localparam logic [2:0] ST_NOTFOUND = 3'd6;
    localparam logic [2:0] ST_NONE     = 3'd7;

endpackage

`default_nettype wire

// ===== rtl/timeout_table_engine.sv =====
// ----------------------------------------------------------------------------
// Timeout table engine
// Table of timeouts with id and deadline, scanned one entry per cycle.
// ----------------------------------------------------------------------------
// Channel   | Direction | Payload
// s_axis    | in        | tdata: cmd, timer_id, duration, interval
// m_axis    | out       | tdata: status, found_id, time_left
// cfg       | in        | largest accepted duration
//
// Every command but tick walks the table once through a single memory read
// port, reading each stored entry in turn, then passes a decide state; the
// result is then offered until taken. A new command is accepted only once the
// block is idle again. Tick skips the walk. Delete and check with removal
// add a shift walk that copies each entry above the removed one one place
// lower; none when the last entry goes. A stalled result holds the block
// until taken. Reset clears the count and the clock; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module timeout_table_engine
    import tte_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,  // cmd[2:0], timer_id[18:3], duration[34:19],
                                       // interval[50:35], zero fill
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // status[2:0], found_id[18:3],
                                       // time_left[34:19], zero fill
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_OUT
    } state_t;

    state_t            state_reg;
    logic [2:0]        cmd_reg;
    logic [15:0]       id_reg, dur_reg, win_reg;
    logic [15:0]       max_reg;
    logic [31:0]       now_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  scan_reg;     // address issued
    logic              rvalid_reg;   // rd_data corresponds to rpos_reg
    logic [IDX_W-1:0]  rpos_reg;
    logic              hit_reg;      // id found / best found
    logic [IDX_W-1:0]  hpos_reg;
    logic [15:0]       bid_reg;
    logic [31:0]       bdl_reg;
    logic              elapsed_reg;  // an entry other than the set id has elapsed
    logic [2:0]        status_reg;
    logic [15:0]       fid_reg, left_reg;
    logic [CNT_W-1:0]  sh_reg;       // shift source index

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [ENTRY_W-1:0] wr_data, rd_data;
    logic [15:0]       e_id;
    logic [31:0]       e_dl;
    logic [32:0]       limit;
    logic [32:0]       sum;
    logic [31:0]       new_dl;
    logic [31:0]       diff;
    logic              set_ok;

    tte_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign e_id      = rd_data[ID_W-1:0];
    assign e_dl      = rd_data[ENTRY_W-1:ID_W];
    assign limit     = {1'b0, now_reg} + {17'd0, win_reg};
    assign sum       = {1'b0, now_reg} + {17'd0, dur_reg};
    assign new_dl    = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign diff      = bdl_reg - now_reg;
    assign set_ok    = (dur_reg != 16'd0) && (dur_reg <= max_reg) && (id_reg != 16'd0) &&
                       (hit_reg || (count_reg < CNT_W'(ENTRIES)));
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !s_tvalid;
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {5'd0, left_reg, fid_reg, status_reg};

    // Read address: scanning issues scan_reg, shifting reads the next source.
    always_comb begin
        rd_addr = scan_reg[IDX_W-1:0];
        if (state_reg == S_DECIDE || state_reg == S_SHIFT) begin
            rd_addr = sh_reg[IDX_W-1:0];
        end
    end

    // Writes: set in S_DECIDE, shift copies in S_SHIFT.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = hpos_reg;
        wr_data = {new_dl, id_reg};
        if (state_reg == S_DECIDE && cmd_reg == CMD_SET && set_ok) begin
            wr_en   = 1'b1;
            wr_addr = hit_reg ? hpos_reg : count_reg[IDX_W-1:0];
        end else if (state_reg == S_SHIFT && rvalid_reg) begin
            wr_en   = 1'b1;
            wr_addr = rpos_reg - IDX_W'(1);
            wr_data = rd_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            now_reg    <= '0;
            max_reg    <= 16'd3600;
            rvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (cfg_valid && cfg_ready) begin
                        max_reg <= cfg_data;
                    end
                    if (s_tvalid) begin
                        cmd_reg     <= s_tdata[2:0];
                        id_reg      <= s_tdata[18:3];
                        dur_reg     <= s_tdata[34:19];
                        win_reg     <= s_tdata[50:35];
                        scan_reg    <= '0;
                        rvalid_reg  <= 1'b0;
                        hit_reg     <= 1'b0;
                        hpos_reg    <= '0;
                        bid_reg     <= '0;
                        bdl_reg     <= '0;
                        elapsed_reg <= 1'b0;
                        status_reg  <= ST_OK;
                        fid_reg     <= '0;
                        left_reg    <= '0;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Evaluate the entry read in the previous cycle.
                    if (rvalid_reg) begin
                        case (cmd_reg)
                            CMD_SET, CMD_DELETE, CMD_GET: begin
                                if (!hit_reg && id_reg != 16'd0 && e_id == id_reg) begin
                                    hit_reg  <= 1'b1;
                                    hpos_reg <= rpos_reg;
                                    bdl_reg  <= e_dl;
                                end
                                // The entry of the set id is rewritten, so its old
                                // deadline does not count.
                                if (e_dl <= now_reg &&
                                    !(id_reg != 16'd0 && e_id == id_reg)) begin
                                    elapsed_reg <= 1'b1;
                                end
                            end
                            CMD_CHECK, CMD_NEAREST: begin
                                if ((cmd_reg == CMD_NEAREST || {1'b0, e_dl} <= limit) &&
                                    (!hit_reg || e_dl < bdl_reg)) begin
                                    hit_reg  <= 1'b1;
                                    hpos_reg <= rpos_reg;
                                    bdl_reg  <= e_dl;
                                    bid_reg  <= e_id;
                                end
                            end
                            default: ;
                        endcase
                    end
                    if (cmd_reg != CMD_TICK && scan_reg < count_reg) begin
                        rvalid_reg <= 1'b1;
                        rpos_reg   <= scan_reg[IDX_W-1:0];
                        scan_reg   <= scan_reg + CNT_W'(1);
                    end else begin
                        rvalid_reg <= 1'b0;
                        state_reg  <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    state_reg <= S_OUT;
                    case (cmd_reg)
                        CMD_TICK: begin
                            if (now_reg != 32'hFFFF_FFFF) begin
                                now_reg <= now_reg + 32'd1;
                            end
                        end
                        CMD_SET: begin
                            if (dur_reg == 16'd0 || dur_reg > max_reg) begin
                                status_reg <= ST_RANGE;
                            end else if (id_reg == 16'd0) begin
                                status_reg <= ST_BAD_ID;
                            end else if (!hit_reg && count_reg >= CNT_W'(ENTRIES)) begin
                                status_reg <= ST_FULL;
                            end else begin
                                if (!hit_reg) begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                                // The new deadline itself counts only once the
                                // clock has reached its maximum.
                                status_reg <= (elapsed_reg || new_dl <= now_reg) ?
                                              ST_ELAPSED : ST_OK;
                            end
                        end
                        CMD_DELETE, CMD_GET: begin
                            if (count_reg == '0) begin
                                status_reg <= ST_EMPTY;
                            end else if (!hit_reg) begin
                                status_reg <= ST_NOTFOUND;
                            end else if (cmd_reg == CMD_GET) begin
                                left_reg <= (bdl_reg <= now_reg) ? 16'd0 :
                                            (diff > 32'hFFFF) ? 16'hFFFF : diff[15:0];
                            end else begin
                                sh_reg    <= {1'b0, hpos_reg} + CNT_W'(1);
                                state_reg <= S_SHIFT;
                            end
                        end
                        CMD_CHECK: begin
                            if (count_reg == '0) begin
                                status_reg <= ST_EMPTY;
                            end else if (!hit_reg) begin
                                status_reg <= ST_NONE;
                            end else begin
                                fid_reg <= bid_reg;
                                if (win_reg == 16'd0) begin
                                    sh_reg    <= {1'b0, hpos_reg} + CNT_W'(1);
                                    state_reg <= S_SHIFT;
                                end
                            end
                        end
                        CMD_NEAREST: begin
                            if (count_reg == '0 || !hit_reg) begin
                                status_reg <= ST_EMPTY;
                            end else begin
                                fid_reg  <= bid_reg;
                                left_reg <= (bdl_reg <= now_reg) ? 16'd0 :
                                            (diff > 32'hFFFF) ? 16'hFFFF : diff[15:0];
                                if (bdl_reg <= now_reg) begin
                                    status_reg <= ST_ELAPSED;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_SHIFT: begin
                    // Read sh_reg, write it one place lower on the next cycle.
                    if (sh_reg < count_reg) begin
                        rvalid_reg <= 1'b1;
                        rpos_reg   <= sh_reg[IDX_W-1:0];
                        sh_reg     <= sh_reg + CNT_W'(1);
                    end else if (!rvalid_reg || rpos_reg != sh_reg[IDX_W-1:0]) begin
                        rvalid_reg <= 1'b0;
                        if (!rvalid_reg) begin
                            count_reg <= count_reg - CNT_W'(1);
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tte_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/tte_checker.sv =====
// ----------------------------------------------------------------------------
// Timeout table engine checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result waits");

    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready |-> !m_tvalid)
        else $error("configuration open while busy");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("repeated result");

    // A configuration transfer never shares a cycle with an input transfer.
    a_cfg_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |-> !(s_tvalid && s_tready))
        else $error("configuration and input in the same cycle");

endmodule

bind timeout_table_engine tte_checker u_tte_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
);

`default_nettype wire
